// ----- hdl/swdh_pkg.sv -----
// Shared types, codes and phase sequencing functions for the SWD host transfer engine.
package swdh_pkg;

  localparam int unsigned CNT_W    = 9;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned HDR_W    = 8;
  localparam int unsigned ACK_W    = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CNT_W-1:0] HDR_LEN  = CNT_W'(8);
  localparam logic [CNT_W-1:0] ACK_LEN  = CNT_W'(3);
  localparam logic [CNT_W-1:0] DATA_LEN = CNT_W'(32 + 1);

  localparam logic [1:0] OP_START_READ  = 2'd0;
  localparam logic [1:0] OP_START_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK        = 2'd2;

  localparam logic [ACK_W-1:0] ACK_OK    = 3'b001;
  localparam logic [ACK_W-1:0] ACK_WAIT  = 3'b010;
  localparam logic [ACK_W-1:0] ACK_FAULT = 3'b100;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_WAIT     = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_FAULT    = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_PROTOCOL = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_PARITY   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_TURNAROUND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_DATA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_COUNT = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_HDR,
    PH_TRN1,
    PH_ACK,
    PH_RDATA,
    PH_TRN2,
    PH_IDLECLK,
    PH_WDATA,
    PH_DUMMY,
    PH_BACKOFF,
    PH_END
  } phase_t;

  typedef struct packed {
    logic [2:0] turnaround;
    logic       force_data;
    logic [7:0] idle_count;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [HDR_W-1:0]  header;
    logic [WORD_W-1:0] write_word;
    logic              swdio;
  } item_t;

  typedef struct packed {
    phase_t            phase;
    logic [CNT_W-1:0]  cnt;
    logic [WORD_W-1:0] data;
    logic [HDR_W-1:0]  hdr;
    logic [ACK_W-1:0]  ack;
    logic              is_read;
    logic              par;
  } state_t;

  typedef struct packed {
    logic                clock_pulse;
    logic                drive_bit;
    logic                drive_enable;
    logic                transfer_done;
    logic [STATUS_W-1:0] status;
    logic [ACK_W-1:0]    ack_bits;
    logic [WORD_W-1:0]   read_word;
  } result_t;

  function automatic logic [CNT_W-1:0] phase_len(phase_t p, cfg_t cfg);
    logic [CNT_W-1:0] len;
    unique case (p) inside
      PH_HDR:                      len = HDR_LEN;
      PH_TRN1, PH_TRN2:            len = CNT_W'(cfg.turnaround);
      PH_ACK:                      len = ACK_LEN;
      PH_RDATA, PH_WDATA, PH_DUMMY: len = DATA_LEN;
      PH_IDLECLK:                  len = CNT_W'(cfg.idle_count);
      PH_BACKOFF:                  len = CNT_W'(cfg.turnaround) + DATA_LEN;
      default:                     len = '0;
    endcase
    return len;
  endfunction

  function automatic phase_t phase_after(phase_t p, logic [ACK_W-1:0] ack, logic is_read,
                                         logic force_data);
    logic   ok;
    logic   wf;
    phase_t nxt;
    ok = (ack == ACK_OK);
    wf = (ack == ACK_WAIT) || (ack == ACK_FAULT);
    unique case (p)
      PH_HDR:  nxt = PH_TRN1;
      PH_TRN1: nxt = PH_ACK;
      PH_ACK: begin
        if (ok) nxt = is_read ? PH_RDATA : PH_TRN2;
        else if (wf) nxt = (is_read && force_data) ? PH_DUMMY : PH_TRN2;
        else nxt = PH_BACKOFF;
      end
      PH_RDATA: nxt = PH_TRN2;
      PH_TRN2: begin
        if (ok) nxt = is_read ? PH_IDLECLK : PH_WDATA;
        else if (!is_read && force_data) nxt = PH_DUMMY;
        else nxt = PH_END;
      end
      PH_WDATA: nxt = PH_IDLECLK;
      PH_DUMMY: nxt = is_read ? PH_TRN2 : PH_END;
      default:  nxt = PH_END;
    endcase
    return nxt;
  endfunction

endpackage

// ----- hdl/swdh_step.sv -----
// Next-state and result logic for one item of the SWD host transfer engine.
module swdh_step (
  input  swdh_pkg::cfg_t    cfg,
  input  swdh_pkg::state_t  st,
  input  swdh_pkg::item_t   item,
  output swdh_pkg::state_t  st_nxt,
  output swdh_pkg::result_t res
);

  logic                        tick;
  logic [1:0]                  ack_pos;
  logic [swdh_pkg::ACK_W-1:0]  ack_upd;
  logic [swdh_pkg::WORD_W-1:0] data_upd;
  logic                        par_upd;
  logic [swdh_pkg::CNT_W-1:0]  cnt_dec;
  swdh_pkg::phase_t            target;
  logic                        finish;

  always_comb begin
    tick     = (item.opcode == swdh_pkg::OP_TICK) && (st.phase != swdh_pkg::PH_IDLE);
    ack_pos  = 2'd3 - st.cnt[1:0];
    ack_upd  = st.ack;
    data_upd = st.data;
    par_upd  = st.par;
    if (tick) begin
      if (st.phase == swdh_pkg::PH_ACK && ack_pos != 2'd3) begin
        ack_upd[ack_pos] = st.ack[ack_pos] | item.swdio;
      end
      if (st.phase == swdh_pkg::PH_RDATA) begin
        if (st.cnt > swdh_pkg::CNT_W'(1)) begin
          data_upd = {item.swdio, st.data[swdh_pkg::WORD_W-1:1]};
        end else begin
          par_upd = (^st.data) ^ item.swdio;
        end
      end else if (st.phase == swdh_pkg::PH_WDATA && st.cnt > swdh_pkg::CNT_W'(1)) begin
        data_upd = {1'b0, st.data[swdh_pkg::WORD_W-1:1]};
      end
    end
    cnt_dec = (st.cnt != '0) ? st.cnt - swdh_pkg::CNT_W'(1) : st.cnt;
    target  = swdh_pkg::phase_after(st.phase, ack_upd, st.is_read, cfg.force_data);
    for (int i = 0; i < 3; i++) begin
      if (target != swdh_pkg::PH_END && swdh_pkg::phase_len(target, cfg) == '0) begin
        target = swdh_pkg::phase_after(target, ack_upd, st.is_read, cfg.force_data);
      end
    end
    finish = tick && (cnt_dec == '0) && (target == swdh_pkg::PH_END);
  end

  always_comb begin
    st_nxt = st;
    case (item.opcode) inside
      swdh_pkg::OP_START_READ, swdh_pkg::OP_START_WRITE: begin
        st_nxt.is_read = (item.opcode == swdh_pkg::OP_START_READ);
        st_nxt.hdr     = item.header;
        st_nxt.data    = st_nxt.is_read ? '0 : item.write_word;
        st_nxt.par     = st_nxt.is_read ? 1'b0 : ^item.write_word;
        st_nxt.ack     = '0;
        st_nxt.phase   = swdh_pkg::PH_HDR;
        st_nxt.cnt     = swdh_pkg::HDR_LEN;
      end
      swdh_pkg::OP_TICK: begin
        if (tick) begin
          st_nxt.ack  = ack_upd;
          st_nxt.data = data_upd;
          st_nxt.par  = par_upd;
          st_nxt.cnt  = cnt_dec;
          if (st.phase == swdh_pkg::PH_HDR) begin
            st_nxt.hdr = {1'b0, st.hdr[swdh_pkg::HDR_W-1:1]};
          end
          if (cnt_dec == '0) begin
            if (target == swdh_pkg::PH_END) begin
              st_nxt.phase = swdh_pkg::PH_IDLE;
            end else begin
              st_nxt.phase = target;
              st_nxt.cnt   = swdh_pkg::phase_len(target, cfg);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res              = '0;
    res.drive_bit    = 1'b1;
    res.drive_enable = 1'b1;
    res.ack_bits     = st_nxt.ack;
    if (tick) begin
      res.clock_pulse  = 1'b1;
      res.drive_bit    = 1'b0;
      res.drive_enable = 1'b0;
      unique case (st.phase)
        swdh_pkg::PH_HDR: begin
          res.drive_enable = 1'b1;
          res.drive_bit    = st.hdr[0];
        end
        swdh_pkg::PH_WDATA: begin
          res.drive_enable = 1'b1;
          res.drive_bit    = (st.cnt > swdh_pkg::CNT_W'(1)) ? st.data[0] : st.par;
        end
        swdh_pkg::PH_DUMMY:   res.drive_enable = !st.is_read;
        swdh_pkg::PH_IDLECLK: res.drive_enable = 1'b1;
        default: begin
        end
      endcase
      if (finish) begin
        res.transfer_done = 1'b1;
        if (ack_upd == swdh_pkg::ACK_OK) begin
          res.status = (st.is_read && par_upd) ? swdh_pkg::STATUS_PARITY : swdh_pkg::STATUS_OK;
          if (st.is_read) res.read_word = data_upd;
        end else if (ack_upd == swdh_pkg::ACK_WAIT) begin
          res.status = swdh_pkg::STATUS_WAIT;
        end else if (ack_upd == swdh_pkg::ACK_FAULT) begin
          res.status = swdh_pkg::STATUS_FAULT;
        end else begin
          res.status = swdh_pkg::STATUS_PROTOCOL;
        end
      end
    end
  end

endmodule

// ----- hdl/swd_host_transfer_engine_core.sv -----
// Top level of the SWD host transfer engine: handshakes, configuration and state registers.
// The engine takes one item per clock cycle while the result side keeps up with out_ready,
// so one tick item can be issued for every SWCLK cycle. An accepted item is held in an
// input register, its result is computed in one pass of logic against the transfer state
// and is loaded into the result register once that register is empty or its result is
// taken. While a result waits on out_ready, an item already in the input register stays
// there and no further item is taken. Configuration writes take effect on the next
// cycle and should be made only while no transfer is in flight.
module swd_host_transfer_engine_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_opcode,
  input  logic [swdh_pkg::HDR_W-1:0]          in_request_header,
  input  logic [swdh_pkg::WORD_W-1:0]         in_write_word,
  input  logic                                in_sampled_swdio,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_clock_pulse,
  output logic                                out_drive_bit,
  output logic                                out_drive_enable,
  output logic                                out_transfer_done,
  output logic [swdh_pkg::STATUS_W-1:0]       out_status,
  output logic [swdh_pkg::ACK_W-1:0]          out_ack_bits,
  output logic [swdh_pkg::WORD_W-1:0]         out_read_word,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swdh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swdh_pkg::CFG_DATA_W-1:0]     cfg_data
);

  swdh_pkg::cfg_t    cfg_r;
  swdh_pkg::cfg_t    cfg_nxt;
  swdh_pkg::item_t   item_r;
  logic              item_v_r;
  logic              item_v_nxt;
  swdh_pkg::state_t  st_r;
  swdh_pkg::state_t  st_nxt;
  swdh_pkg::result_t res;
  swdh_pkg::result_t res_r;
  logic              out_v_r;
  logic              out_v_nxt;
  logic              adv;
  logic              in_take;

  assign adv       = item_v_r && (!out_v_r || out_ready);
  assign in_ready  = !item_v_r || adv;
  assign in_take   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign item_v_nxt = in_take ? 1'b1 : (adv ? 1'b0 : item_v_r);
  assign out_v_nxt  = adv ? 1'b1 : (out_ready ? 1'b0 : out_v_r);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        swdh_pkg::CFG_TURNAROUND: cfg_nxt.turnaround = cfg_data[2:0];
        swdh_pkg::CFG_FORCE_DATA: cfg_nxt.force_data = cfg_data[0];
        swdh_pkg::CFG_IDLE_COUNT: cfg_nxt.idle_count = cfg_data;
        default: begin
        end
      endcase
    end
  end

  swdh_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.turnaround <= 3'd1;
      cfg_r.force_data <= 1'b0;
      cfg_r.idle_count <= '0;
      item_v_r         <= 1'b0;
      out_v_r          <= 1'b0;
      st_r.phase       <= swdh_pkg::PH_IDLE;
      st_r.cnt         <= '0;
      st_r.data        <= '0;
      st_r.hdr         <= '0;
      st_r.ack         <= '0;
      st_r.is_read     <= 1'b0;
      st_r.par         <= 1'b0;
    end else begin
      cfg_r    <= cfg_nxt;
      item_v_r <= item_v_nxt;
      out_v_r  <= out_v_nxt;
      if (adv) st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.opcode     <= in_opcode;
      item_r.header     <= in_request_header;
      item_r.write_word <= in_write_word;
      item_r.swdio      <= in_sampled_swdio;
    end
    if (adv) res_r <= res;
  end

  assign out_valid         = out_v_r;
  assign out_clock_pulse   = res_r.clock_pulse;
  assign out_drive_bit     = res_r.drive_bit;
  assign out_drive_enable  = res_r.drive_enable;
  assign out_transfer_done = res_r.transfer_done;
  assign out_status        = res_r.status;
  assign out_ack_bits      = res_r.ack_bits;
  assign out_read_word     = res_r.read_word;

`ifndef ASSERT_OFF
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase != swdh_pkg::PH_IDLE |-> st_r.cnt != '0)
    else $error("Active phase with an exhausted cycle counter.");

  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    adv && st_r.phase == swdh_pkg::PH_IDLE && item_r.opcode == swdh_pkg::OP_TICK
    |=> st_r.phase == swdh_pkg::PH_IDLE)
    else $error("A tick while idle started a transfer.");

  a_done_clocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.transfer_done |-> res_r.clock_pulse)
    else $error("Transfer reported done without a clock pulse.");

  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !res_r.transfer_done |-> res_r.status == swdh_pkg::STATUS_OK
      && res_r.read_word == '0)
    else $error("Status or read data reported before the transfer ended.");

  a_released_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !res_r.drive_enable |-> !res_r.drive_bit)
    else $error("Drive bit set while the line is released.");
`endif

endmodule

// ----- bench/swd_host_transfer_engine_core_tb.sv -----
// Self-checking testbench for the SWD host transfer engine core.
module swd_host_transfer_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]                     OP_NOOP      = 2'd3;
  localparam logic [swdh_pkg::ACK_W-1:0]     ACK_NONE     = 3'b000;
  localparam logic [swdh_pkg::ACK_W-1:0]     ACK_ALL_ONES = 3'b111;
  localparam logic [swdh_pkg::ACK_W-1:0]     ACK_ODD      = 3'b110;
  localparam logic [swdh_pkg::ACK_W-1:0]     ACK_LOW_TWO  = 3'b011;
  localparam logic [swdh_pkg::CFG_IDX_W-1:0] CFG_UNUSED   = 2'd3;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic [1:0]                      in_opcode;
  logic [swdh_pkg::HDR_W-1:0]      in_request_header;
  logic [swdh_pkg::WORD_W-1:0]     in_write_word;
  logic                            in_sampled_swdio;
  logic                            out_valid;
  logic                            out_ready;
  logic                            out_clock_pulse;
  logic                            out_drive_bit;
  logic                            out_drive_enable;
  logic                            out_transfer_done;
  logic [swdh_pkg::STATUS_W-1:0]   out_status;
  logic [swdh_pkg::ACK_W-1:0]      out_ack_bits;
  logic [swdh_pkg::WORD_W-1:0]     out_read_word;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [swdh_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [swdh_pkg::CFG_DATA_W-1:0] cfg_data;

  swd_host_transfer_engine_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_request_header (in_request_header),
    .in_write_word     (in_write_word),
    .in_sampled_swdio  (in_sampled_swdio),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_clock_pulse   (out_clock_pulse),
    .out_drive_bit     (out_drive_bit),
    .out_drive_enable  (out_drive_enable),
    .out_transfer_done (out_transfer_done),
    .out_status        (out_status),
    .out_ack_bits      (out_ack_bits),
    .out_read_word     (out_read_word),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  swdh_pkg::phase_t           eng_phase;
  logic [swdh_pkg::CNT_W-1:0] eng_cnt;
  logic [31:0]                eng_data;
  logic [7:0]                 eng_hdr;
  logic [2:0]                 eng_ack;
  logic                       eng_rd;
  logic                       eng_par;
  logic [2:0]                 set_turn;
  logic                       set_force;
  logic [7:0]                 set_idle;

  int unsigned drv_turn;
  bit          drv_force;
  int unsigned drv_idle;
  int unsigned send_idle_pct;
  int unsigned sink_stall_pct;
  int          items_sent;
  int          errors_seen;

  swdh_pkg::result_t expected_cycles[$];

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic logic [swdh_pkg::CNT_W-1:0] span_of(swdh_pkg::phase_t p);
    case (p) inside
      swdh_pkg::PH_HDR:                  return swdh_pkg::CNT_W'(8);
      swdh_pkg::PH_TRN1, swdh_pkg::PH_TRN2:
        return swdh_pkg::CNT_W'(set_turn);
      swdh_pkg::PH_ACK:                  return swdh_pkg::CNT_W'(3);
      swdh_pkg::PH_RDATA, swdh_pkg::PH_WDATA, swdh_pkg::PH_DUMMY:
        return swdh_pkg::CNT_W'(33);
      swdh_pkg::PH_IDLECLK:              return swdh_pkg::CNT_W'(set_idle);
      swdh_pkg::PH_BACKOFF:
        return swdh_pkg::CNT_W'(set_turn) + swdh_pkg::CNT_W'(33);
      default:                           return '0;
    endcase
  endfunction

  function automatic swdh_pkg::phase_t next_phase(swdh_pkg::phase_t p);
    logic ok;
    logic wait_or_fault;
    ok = (eng_ack == swdh_pkg::ACK_OK);
    wait_or_fault = (eng_ack == swdh_pkg::ACK_WAIT) || (eng_ack == swdh_pkg::ACK_FAULT);
    case (p)
      swdh_pkg::PH_HDR:  return swdh_pkg::PH_TRN1;
      swdh_pkg::PH_TRN1: return swdh_pkg::PH_ACK;
      swdh_pkg::PH_ACK: begin
        if (ok) return eng_rd ? swdh_pkg::PH_RDATA : swdh_pkg::PH_TRN2;
        if (wait_or_fault) begin
          return (eng_rd && set_force) ? swdh_pkg::PH_DUMMY : swdh_pkg::PH_TRN2;
        end
        return swdh_pkg::PH_BACKOFF;
      end
      swdh_pkg::PH_RDATA: return swdh_pkg::PH_TRN2;
      swdh_pkg::PH_TRN2: begin
        if (ok) return eng_rd ? swdh_pkg::PH_IDLECLK : swdh_pkg::PH_WDATA;
        if (!eng_rd && set_force) return swdh_pkg::PH_DUMMY;
        return swdh_pkg::PH_END;
      end
      swdh_pkg::PH_WDATA: return swdh_pkg::PH_IDLECLK;
      swdh_pkg::PH_DUMMY: return eng_rd ? swdh_pkg::PH_TRN2 : swdh_pkg::PH_END;
      default:            return swdh_pkg::PH_END;
    endcase
  endfunction

  function automatic void advance_swd_engine(input logic [1:0] op, input logic [7:0] hdr,
                                             input logic [31:0] word, input logic s,
                                             output swdh_pkg::result_t res);
    swdh_pkg::phase_t nxt;
    logic [1:0]       pos;
    res = '0;
    res.drive_bit = 1'b1;
    res.drive_enable = 1'b1;
    if (op == swdh_pkg::OP_START_READ || op == swdh_pkg::OP_START_WRITE) begin
      eng_rd = (op == swdh_pkg::OP_START_READ);
      eng_hdr = hdr;
      eng_data = eng_rd ? 32'd0 : word;
      eng_par = eng_rd ? 1'b0 : ^word;
      eng_ack = '0;
      eng_phase = swdh_pkg::PH_HDR;
      eng_cnt = swdh_pkg::CNT_W'(8);
    end else if (op == swdh_pkg::OP_TICK && eng_phase != swdh_pkg::PH_IDLE) begin
      res.clock_pulse = 1'b1;
      res.drive_bit = 1'b0;
      res.drive_enable = 1'b0;
      case (eng_phase)
        swdh_pkg::PH_HDR: begin
          res.drive_enable = 1'b1;
          res.drive_bit = eng_hdr[0];
          eng_hdr = eng_hdr >> 1;
        end
        swdh_pkg::PH_ACK: begin
          pos = 2'(swdh_pkg::CNT_W'(3) - eng_cnt);
          if (pos < 2'd3) eng_ack = eng_ack | (3'(s) << pos);
        end
        swdh_pkg::PH_RDATA: begin
          if (eng_cnt > 1) eng_data = {s, eng_data[31:1]};
          else eng_par = (^eng_data) ^ s;
        end
        swdh_pkg::PH_WDATA: begin
          res.drive_enable = 1'b1;
          if (eng_cnt > 1) begin
            res.drive_bit = eng_data[0];
            eng_data = eng_data >> 1;
          end else begin
            res.drive_bit = eng_par;
          end
        end
        swdh_pkg::PH_DUMMY: begin
          if (!eng_rd) res.drive_enable = 1'b1;
        end
        swdh_pkg::PH_IDLECLK: begin
          res.drive_enable = 1'b1;
        end
        default: begin
        end
      endcase
      if (eng_cnt > 0) eng_cnt = eng_cnt - 1'b1;
      if (eng_cnt == 0) begin
        nxt = next_phase(eng_phase);
        while (nxt != swdh_pkg::PH_END && span_of(nxt) == 0) nxt = next_phase(nxt);
        if (nxt == swdh_pkg::PH_END) begin
          res.transfer_done = 1'b1;
          if (eng_ack == swdh_pkg::ACK_OK) begin
            res.status = (eng_rd && eng_par) ? swdh_pkg::STATUS_PARITY : swdh_pkg::STATUS_OK;
            if (eng_rd) res.read_word = eng_data;
          end else if (eng_ack == swdh_pkg::ACK_WAIT) begin
            res.status = swdh_pkg::STATUS_WAIT;
          end else if (eng_ack == swdh_pkg::ACK_FAULT) begin
            res.status = swdh_pkg::STATUS_FAULT;
          end else begin
            res.status = swdh_pkg::STATUS_PROTOCOL;
          end
          eng_phase = swdh_pkg::PH_IDLE;
        end else begin
          eng_phase = nxt;
          eng_cnt = span_of(nxt);
        end
      end
    end
    res.ack_bits = eng_ack;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
    if (want !== seen) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, seen);
      errors_seen++;
    end
  endfunction

  always @(posedge clk) begin
    swdh_pkg::result_t want;
    swdh_pkg::result_t predicted;
    if (!rst_n) begin
      eng_phase = swdh_pkg::PH_IDLE;
      eng_cnt = '0;
      eng_data = '0;
      eng_hdr = '0;
      eng_ack = '0;
      eng_rd = 1'b0;
      eng_par = 1'b0;
      set_turn = 3'd1;
      set_force = 1'b0;
      set_idle = 8'd0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_cycles.size() == 0) begin
          $error("result transfer arrived with no expected result pending");
          errors_seen++;
        end else begin
          want = expected_cycles.pop_front();
          check_field("clock_pulse", 32'(want.clock_pulse), 32'(out_clock_pulse));
          check_field("drive_bit", 32'(want.drive_bit), 32'(out_drive_bit));
          check_field("drive_enable", 32'(want.drive_enable), 32'(out_drive_enable));
          check_field("transfer_done", 32'(want.transfer_done), 32'(out_transfer_done));
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("ack_bits", 32'(want.ack_bits), 32'(out_ack_bits));
          check_field("read_word", want.read_word, out_read_word);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          swdh_pkg::CFG_TURNAROUND: set_turn = cfg_data[2:0];
          swdh_pkg::CFG_FORCE_DATA: set_force = cfg_data[0];
          swdh_pkg::CFG_IDLE_COUNT: set_idle = cfg_data;
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) begin
        advance_swd_engine(in_opcode, in_request_header, in_write_word, in_sampled_swdio,
                           predicted);
        expected_cycles.push_back(predicted);
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] hdr, input logic [31:0] word,
                           input logic swdio);
    int gap;
    gap = 0;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_request_header <= hdr;
    in_write_word <= word;
    in_sampled_swdio <= swdio;
    items_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_cycles.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [swdh_pkg::CFG_IDX_W-1:0] idx,
                           input logic [swdh_pkg::CFG_DATA_W-1:0] value);
    wait_drained();
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input int unsigned turn, input bit force_dummy,
                           input int unsigned idle);
    write_reg(swdh_pkg::CFG_TURNAROUND, swdh_pkg::CFG_DATA_W'(turn));
    write_reg(swdh_pkg::CFG_FORCE_DATA, swdh_pkg::CFG_DATA_W'(force_dummy));
    write_reg(swdh_pkg::CFG_IDLE_COUNT, swdh_pkg::CFG_DATA_W'(idle));
    drv_turn = turn & 7;
    drv_force = force_dummy;
    drv_idle = idle & 8'hFF;
  endtask

  function automatic int transfer_ticks(input logic [2:0] ack);
    int n;
    n = 8 + drv_turn + 3;
    if (ack == swdh_pkg::ACK_OK) begin
      n += 33 + drv_turn + drv_idle;
    end else if (ack == swdh_pkg::ACK_WAIT || ack == swdh_pkg::ACK_FAULT) begin
      n += drv_turn + (drv_force ? 33 : 0);
    end else begin
      n += drv_turn + 33;
    end
    return n;
  endfunction

  function automatic logic [2:0] pick_ack();
    int r;
    logic [2:0] a;
    r = $urandom_range(99);
    if (r < 50) return swdh_pkg::ACK_OK;
    if (r < 65) return swdh_pkg::ACK_WAIT;
    if (r < 80) return swdh_pkg::ACK_FAULT;
    do a = 3'($urandom_range(7));
    while (a == swdh_pkg::ACK_OK || a == swdh_pkg::ACK_WAIT || a == swdh_pkg::ACK_FAULT);
    return a;
  endfunction

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(7);
    if (r == 0) return 32'hFFFF_FFFF;
    if (r == 1) return 32'h0000_0000;
    return $urandom;
  endfunction

  // A cut point below the tick count abandons the transfer after that many ticks.
  task automatic run_transfer(input bit rd, input logic [7:0] hdr, input logic [31:0] word,
                              input logic [2:0] ack, input logic [31:0] rdata, input bit bad_par,
                              input int cut_at);
    int   n;
    int   pos;
    logic s;
    n = transfer_ticks(ack);
    send_item(rd ? swdh_pkg::OP_START_READ : swdh_pkg::OP_START_WRITE, hdr, word,
              1'($urandom_range(1)));
    for (int i = 0; i < n; i++) begin
      if (i == cut_at) return;
      if ($urandom_range(19) == 0) begin
        send_item(OP_NOOP, 8'($urandom_range(255)), $urandom, 1'($urandom_range(1)));
      end
      pos = i - 8 - int'(drv_turn);
      s = 1'($urandom_range(1));
      if (pos >= 0 && pos < 3) s = ack[pos];
      else if (rd && ack == swdh_pkg::ACK_OK && pos >= 3 && pos < 35) s = rdata[pos-3];
      else if (rd && ack == swdh_pkg::ACK_OK && pos == 35) s = (^rdata) ^ bad_par;
      send_item(swdh_pkg::OP_TICK, 8'($urandom_range(255)), $urandom, s);
    end
  endtask

  task automatic random_transfer(input bit abandon);
    bit         rd;
    logic [2:0] ack;
    int         cut_at;
    rd = 1'($urandom_range(1));
    ack = pick_ack();
    cut_at = abandon ? $urandom_range(transfer_ticks(ack) - 1) : -1;
    run_transfer(rd, 8'($urandom_range(255)), pick_word(), ack, pick_word(),
                 $urandom_range(9) == 0, cut_at);
  endtask

  task automatic test_idle_and_noop();
    send_item(swdh_pkg::OP_TICK, 8'h00, 32'h0, 1'b1);
    send_item(OP_NOOP, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    run_transfer(1'b1, 8'hA5, 32'h0, swdh_pkg::ACK_OK, 32'h1234_5678, 1'b0, -1);
    send_item(OP_NOOP, 8'h5A, 32'hDEAD_BEEF, 1'b0);
    send_item(swdh_pkg::OP_TICK, 8'hFF, 32'hFFFF_FFFF, 1'b0);
  endtask

  task automatic test_extreme_settings();
    configure(0, 1'b1, 255);
    write_reg(CFG_UNUSED, 8'hFF);
    run_transfer(1'b0, 8'hFF, 32'hFFFF_FFFF, swdh_pkg::ACK_OK, 32'h0, 1'b0, -1);
    configure(0, 1'b0, 0);
    run_transfer(1'b1, 8'h81, 32'h0, swdh_pkg::ACK_OK, 32'h8000_0001, 1'b0, -1);
    run_transfer(1'b0, 8'h7E, 32'h0000_0001, swdh_pkg::ACK_WAIT, 32'h0, 1'b0, -1);
  endtask

  task automatic test_ack_paths();
    configure(4, 1'b1, 2);
    run_transfer(1'b1, 8'hA5, 32'h0, swdh_pkg::ACK_WAIT, 32'h0, 1'b0, -1);
    run_transfer(1'b0, 8'hB1, 32'h5555_5555, swdh_pkg::ACK_FAULT, 32'h0, 1'b0, -1);
    run_transfer(1'b1, 8'h8D, 32'h0, ACK_ALL_ONES, 32'h0, 1'b0, -1);
    run_transfer(1'b0, 8'h99, 32'hAAAA_AAAA, ACK_NONE, 32'h0, 1'b0, -1);
    run_transfer(1'b1, 8'hA5, 32'h0, swdh_pkg::ACK_OK, 32'h8000_0001, 1'b1, -1);
    configure(2, 1'b0, 1);
    run_transfer(1'b1, 8'hC3, 32'h0, swdh_pkg::ACK_FAULT, 32'h0, 1'b0, -1);
    run_transfer(1'b0, 8'h3C, 32'h0F0F_0F0F, swdh_pkg::ACK_WAIT, 32'h0, 1'b0, -1);
    run_transfer(1'b1, 8'hE7, 32'h0, ACK_LOW_TWO, 32'h0, 1'b0, -1);
    run_transfer(1'b0, 8'h18, 32'h1357_9BDF, swdh_pkg::ACK_OK, 32'h0, 1'b0, -1);
  endtask

  task automatic test_turnaround_above_range();
    configure(7, 1'b0, 1);
    run_transfer(1'b0, 8'hF0, 32'hCAFE_F00D, swdh_pkg::ACK_OK, 32'h0, 1'b0, -1);
    run_transfer(1'b1, 8'h0F, 32'h0, swdh_pkg::ACK_OK, 32'h0BAD_CAFE, 1'b0, -1);
    run_transfer(1'b1, 8'h55, 32'h0, ACK_ODD, 32'h0, 1'b0, -1);
  endtask

  task automatic test_start_while_busy();
    configure(1, 1'b0, 0);
    run_transfer(1'b1, 8'hA5, 32'h0, swdh_pkg::ACK_OK, 32'hFFFF_0000, 1'b0, 20);
    run_transfer(1'b0, 8'hB3, 32'h8765_4321, swdh_pkg::ACK_OK, 32'h0, 1'b0, 3);
    run_transfer(1'b0, 8'hB3, 32'h8765_4321, swdh_pkg::ACK_OK, 32'h0, 1'b0, 30);
    run_transfer(1'b1, 8'h8F, 32'h0, swdh_pkg::ACK_OK, 32'h0F0F_1234, 1'b0, -1);
  endtask

  task automatic test_random_traffic();
    int target;
    int r;
    int mode;
    for (int k = 0; k < 8; k++) begin
      case (k)
        0:       configure(1, 1'b0, 0);
        1:       configure(4, 1'b1, 3);
        2:       configure(0, 1'b1, 0);
        3:       configure(7, 1'b0, 2);
        default: configure($urandom_range(7), 1'($urandom_range(1)), $urandom_range(10));
      endcase
      mode = k % 4;
      send_idle_pct = (mode == 1) ? 67 : (mode == 3) ? 11 : 0;
      sink_stall_pct = (mode == 2) ? 67 : (mode == 3) ? 11 : 0;
      target = items_sent + 40;
      while (items_sent < target) begin
        r = $urandom_range(99);
        if (r < 65) begin
          random_transfer(1'b0);
        end else if (r < 80) begin
          random_transfer(1'b1);
        end else if (r < 97) begin
          send_item(2'($urandom_range(3)), 8'($urandom_range(255)), $urandom,
                    1'($urandom_range(1)));
        end else begin
          wait_drained();
        end
      end
    end
    send_idle_pct = 0;
    sink_stall_pct = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = swdh_pkg::OP_TICK;
    in_request_header = '0;
    in_write_word = '0;
    in_sampled_swdio = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = swdh_pkg::CFG_TURNAROUND;
    cfg_data = '0;
    send_idle_pct = 0;
    sink_stall_pct = 0;
    drv_turn = 1;
    drv_force = 1'b0;
    drv_idle = 0;
    items_sent = 0;
    errors_seen = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    test_idle_and_noop();
    test_extreme_settings();
    test_ack_paths();
    test_turnaround_above_range();
    test_start_while_busy();
    test_random_traffic();
    wait_drained();
    repeat (12) @(negedge clk);
    if (errors_seen == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
